// ===== hdl/enbt_pkg.sv =====
// Shared constants, codes and port word layouts for the expiring node block table.
package enbt_pkg;

   // Default sizes
   localparam int DEF_MAX_NODES   = 16;
   localparam int DEF_MAX_ENTRIES = 8;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_TIME_BITS   = 48;

   // Fixed field widths
   localparam int DUR_BITS    = 32;
   localparam int REASON_BITS = 16;
   localparam int KIND_BITS   = 2;

   // Operation codes
   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_LIST  = 2'd2;

   // Directive kinds
   localparam logic [1:0] KIND_ELEVATE    = 2'd0;
   localparam logic [1:0] KIND_AVOID      = 2'd1;
   localparam logic [1:0] KIND_QUARANTINE = 2'd2;
   localparam logic [1:0] KIND_RELEASE    = 2'd3;

   // Input word, last declared field in the lowest bits
   typedef struct packed {
      logic [3:0]  pad;
      logic [47:0] now_ms;
      logic [15:0] reason_tag;
      logic [47:0] issued_ms;
      logic [31:0] lifetime_ms;
      logic        timed;
      logic [1:0]  kind;
      logic        node_present;
      logic [31:0] node_key;
   } req_data_type;

   // Result word, last declared field in the lowest bits
   typedef struct packed {
      logic [1:0]  pad;
      logic        dropped;
      logic [15:0] entry_reason;
      logic [47:0] entry_issued;
      logic [31:0] entry_duration;
      logic        entry_timed;
      logic [1:0]  entry_kind;
      logic [4:0]  tracked_nodes;
      logic [3:0]  active_count;
      logic [15:0] block_reason;
      logic        blocked;
   } rsp_data_type;

endpackage

// ===== hdl/enbt_ram.sv =====
// Single write port, single registered read port memory.
module enbt_ram
   import enbt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/enbt_expiry_unit.sv =====
// Shared expiry test: issued + duration <= now, computed without wrap.
module enbt_expiry_unit
   import enbt_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 timed,
   input  logic [TIME_BITS-1:0] issued,
   input  logic [DUR_BITS-1:0]  duration,
   input  logic [TIME_BITS-1:0] now,
   output logic                 expired
);

   logic [TIME_BITS:0] sum;

   // one wide add and compare; untimed entries never expire
   assign sum     = {1'b0, issued} + (TIME_BITS+1)'(duration);
   assign expired = timed && (sum <= {1'b0, now});

endmodule

// ===== hdl/expiring_node_block_table.sv =====
// Top level: node directory scan, entry purge/list sequencer and result register.
//
//  channel | direction | handshake             | word
//  req_    | in        | req_tvalid/req_tready | tdata: directive/query fields, tuser: op
//  rsp_    | out       | rsp_tvalid/rsp_tready | tdata: answer/entry, tuser: entry_valid
//
// An item with a present node and a known op first scans the node directory,
// reading then checking each slot. Query and listing then walk the node's list
// through the one expiry unit, reading then checking each entry; a listing
// walks it twice (count, then stream). A store writes in the dispatch state.
// Synchronous reset clears the valid bits, node count and sequencer; memories
// are not cleared. req_tready is low until the item's last word is taken.
module expiring_node_block_table
   import enbt_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // node_key, node_present, kind, timed, lifetime_ms, issued_ms, reason_tag, now_ms
   input  logic [183:0] req_tdata,
   // op
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // blocked, block_reason, active_count, tracked_nodes, entry_kind, entry_timed,
   // entry_duration, entry_issued, entry_reason, dropped
   output logic [127:0] rsp_tdata,
   // entry_valid
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   localparam int NI_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NC_W   = $clog2(MAX_NODES + 1);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int EDEPTH = MAX_NODES * MAX_ENTRIES;
   localparam int EA_W   = $clog2(EDEPTH);
   localparam int NW     = CNT_W + KEY_BITS;
   localparam int EW     = TIME_BITS + DUR_BITS + 1 + REASON_BITS + KIND_BITS;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_SCAN_RD  = 13'b0000000000010,
      ST_SCAN_CHK = 13'b0000000000100,
      ST_DISPATCH = 13'b0000000001000,
      ST_P_RD     = 13'b0000000010000,
      ST_P_CHK    = 13'b0000000100000,
      ST_P_END    = 13'b0000001000000,
      ST_C_RD     = 13'b0000010000000,
      ST_C_CHK    = 13'b0000100000000,
      ST_S_RD     = 13'b0001000000000,
      ST_S_CHK    = 13'b0010000000000,
      ST_FINISH   = 13'b0100000000000,
      ST_RESP     = 13'b1000000000000
   } state_type;

   req_data_type req_word;
   assign req_word = req_tdata;

   // control registers
   state_type             state_ff, state_in;
   logic [MAX_NODES-1:0]  used_ff, used_in;
   logic [NC_W-1:0]       tracked_ff, tracked_in;

   // item registers
   logic [1:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [1:0]            kind_ff, kind_in;
   logic                  timed_ff, timed_in;
   logic [DUR_BITS-1:0]   dur_ff, dur_in;
   logic [TIME_BITS-1:0]  iss_ff, iss_in;
   logic [REASON_BITS-1:0] reason_ff, reason_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;

   // scan and walk registers
   logic [NC_W-1:0]       scan_ff, scan_in;
   logic                  hit_ff, hit_in;
   logic [NI_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                  free_ok_ff, free_ok_in;
   logic [NI_W-1:0]       free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic [CNT_W-1:0]      w_ff, w_in;
   logic [CNT_W-1:0]      emit_ff, emit_in;
   logic                  found_ff, found_in;
   logic [TIME_BITS-1:0]  best_t_ff, best_t_in;
   logic [REASON_BITS-1:0] best_r_ff, best_r_in;
   logic                  drop_ff, drop_in;
   logic                  stream_ff, stream_in;

   // result register
   rsp_data_type          rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memory ports
   logic                  node_wr_en, node_rd_en;
   logic [NI_W-1:0]       node_wr_addr, node_rd_addr;
   logic [NW-1:0]         node_wr_data, node_rd_data;
   logic                  ent_wr_en, ent_rd_en;
   logic [EA_W-1:0]       ent_wr_addr, ent_rd_addr;
   logic [EW-1:0]         ent_wr_data, ent_rd_data;

   // read entry fields
   logic [TIME_BITS-1:0]  ent_iss;
   logic [DUR_BITS-1:0]   ent_dur;
   logic                  ent_timed;
   logic [REASON_BITS-1:0] ent_reason;
   logic [1:0]            ent_kind;
   logic                  ent_expired;
   logic [KEY_BITS-1:0]   node_key_q;
   logic [CNT_W-1:0]      node_cnt_q;
   logic [NI_W-1:0]       scan_idx;
   logic [EA_W-1:0]       ent_base;
   logic [NI_W-1:0]       slot;
   logic [CNT_W-1:0]      slot_cnt;

   assign ent_iss    = ent_rd_data[TIME_BITS-1:0];
   assign ent_dur    = ent_rd_data[TIME_BITS+DUR_BITS-1:TIME_BITS];
   assign ent_timed  = ent_rd_data[TIME_BITS+DUR_BITS];
   assign ent_reason = ent_rd_data[TIME_BITS+DUR_BITS+REASON_BITS:TIME_BITS+DUR_BITS+1];
   assign ent_kind   = ent_rd_data[EW-1:EW-KIND_BITS];
   assign node_key_q = node_rd_data[KEY_BITS-1:0];
   assign node_cnt_q = node_rd_data[NW-1:KEY_BITS];
   assign scan_idx   = scan_ff[NI_W-1:0];
   assign ent_base   = EA_W'(hit_idx_ff) * EA_W'(MAX_ENTRIES);
   assign slot       = hit_ff ? hit_idx_ff : free_idx_ff;
   assign slot_cnt   = hit_ff ? cnt_ff : '0;

   enbt_ram #(.DEPTH(MAX_NODES), .WIDTH(NW), .AW(NI_W)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   enbt_ram #(.DEPTH(EDEPTH), .WIDTH(EW), .AW(EA_W)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   enbt_expiry_unit #(.TIME_BITS(TIME_BITS)) u_expiry (
      .timed    (ent_timed),
      .issued   (ent_iss),
      .duration (ent_dur),
      .now      (now_ff),
      .expired  (ent_expired)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      tracked_in  = tracked_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      kind_in     = kind_ff;
      timed_in    = timed_ff;
      dur_in      = dur_ff;
      iss_in      = iss_ff;
      reason_in   = reason_ff;
      now_in      = now_ff;
      scan_in     = scan_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      w_in        = w_ff;
      emit_in     = emit_ff;
      found_in    = found_ff;
      best_t_in   = best_t_ff;
      best_r_in   = best_r_ff;
      drop_in     = drop_ff;
      stream_in   = stream_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;

      node_wr_en   = 1'b0;
      node_wr_addr = slot;
      node_wr_data = {CNT_W'(slot_cnt + CNT_W'(1)), key_ff};
      node_rd_en   = 1'b0;
      node_rd_addr = scan_idx;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = ent_base + EA_W'(w_ff);
      ent_wr_data  = ent_rd_data;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = ent_base + EA_W'(i_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               key_in      = KEY_BITS'(req_word.node_key);
               kind_in     = req_word.kind;
               timed_in    = req_word.timed;
               dur_in      = req_word.lifetime_ms;
               iss_in      = TIME_BITS'(req_word.issued_ms);
               reason_in   = req_word.reason_tag;
               now_in      = TIME_BITS'(req_word.now_ms);
               scan_in     = '0;
               hit_in      = 1'b0;
               free_ok_in  = 1'b0;
               cnt_in      = '0;
               i_in        = '0;
               w_in        = '0;
               emit_in     = '0;
               found_in    = 1'b0;
               best_t_in   = '0;
               best_r_in   = '0;
               drop_in     = 1'b0;
               stream_in   = 1'b0;
               // blank node or unused op: answer at once
               if (!req_word.node_present || !(req_tuser == OP_STORE ||
                   req_tuser == OP_QUERY || req_tuser == OP_LIST)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            node_rd_en = 1'b1;
            state_in   = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // match on a used slot, and note the lowest free slot
            if (used_ff[scan_idx] && node_key_q == key_ff && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_idx;
               cnt_in     = node_cnt_q;
            end
            if (!used_ff[scan_idx] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = scan_idx;
            end
            scan_in = scan_ff + NC_W'(1);
            if (scan_ff == NC_W'(MAX_NODES - 1)) begin
               state_in = ST_DISPATCH;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            case (op_ff)
               OP_STORE: begin
                  if (kind_ff == KIND_RELEASE) begin
                     if (hit_ff) begin
                        used_in[hit_idx_ff] = 1'b0;
                        tracked_in = tracked_ff - NC_W'(1);
                     end
                  end else if ((!hit_ff && !free_ok_ff) ||
                               (hit_ff && cnt_ff >= CNT_W'(MAX_ENTRIES))) begin
                     drop_in = 1'b1;
                  end else begin
                     // append at the end of the list, allocating if new
                     ent_wr_en   = 1'b1;
                     ent_wr_addr = EA_W'(slot) * EA_W'(MAX_ENTRIES) + EA_W'(slot_cnt);
                     ent_wr_data = {kind_ff, reason_ff, timed_ff, dur_ff, iss_ff};
                     node_wr_en  = 1'b1;
                     if (!hit_ff) begin
                        used_in[free_idx_ff] = 1'b1;
                        tracked_in = tracked_ff + NC_W'(1);
                     end
                  end
               end
               OP_QUERY: begin
                  if (hit_ff) begin
                     state_in = ST_P_RD;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     state_in = ST_C_RD;
                  end
               end
            endcase
         end
         // purge pass: compact live entries, track newest blocking one
         ST_P_RD: begin
            if (i_ff == cnt_ff) begin
               state_in = ST_P_END;
            end else begin
               ent_rd_en = 1'b1;
               state_in  = ST_P_CHK;
            end
         end
         ST_P_CHK: begin
            if (!ent_expired) begin
               ent_wr_en = 1'b1;
               w_in      = w_ff + CNT_W'(1);
               if ((ent_kind == KIND_AVOID || ent_kind == KIND_QUARANTINE) &&
                   (!found_ff || ent_iss >= best_t_ff)) begin
                  found_in  = 1'b1;
                  best_t_in = ent_iss;
                  best_r_in = ent_reason;
               end
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_P_RD;
         end
         ST_P_END: begin
            node_wr_en   = 1'b1;
            node_wr_addr = hit_idx_ff;
            node_wr_data = {w_ff, key_ff};
            if (w_ff == '0) begin
               used_in[hit_idx_ff] = 1'b0;
               tracked_in = tracked_ff - NC_W'(1);
               found_in   = 1'b0;
            end
            state_in = ST_FINISH;
         end
         // count pass for a listing
         ST_C_RD: begin
            if (i_ff == cnt_ff) begin
               i_in = '0;
               if (w_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_S_RD;
               end
            end else begin
               ent_rd_en = 1'b1;
               state_in  = ST_C_CHK;
            end
         end
         ST_C_CHK: begin
            if (!ent_expired) begin
               w_in = w_ff + CNT_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_C_RD;
         end
         // stream pass: one result word per live entry
         ST_S_RD: begin
            ent_rd_en = 1'b1;
            state_in  = ST_S_CHK;
         end
         ST_S_CHK: begin
            i_in = i_ff + CNT_W'(1);
            if (ent_expired) begin
               state_in = ST_S_RD;
            end else begin
               rsp_data_in                = '0;
               rsp_data_in.tracked_nodes  = 5'(tracked_ff);
               rsp_data_in.active_count   = 4'(w_ff);
               rsp_data_in.entry_kind     = ent_kind;
               rsp_data_in.entry_timed    = ent_timed;
               rsp_data_in.entry_duration = ent_dur;
               rsp_data_in.entry_issued   = 48'(ent_iss);
               rsp_data_in.entry_reason   = ent_reason;
               rsp_user_in = 1'b1;
               rsp_last_in = (emit_ff + CNT_W'(1) == w_ff);
               emit_in     = emit_ff + CNT_W'(1);
               stream_in   = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_FINISH: begin
            rsp_data_in               = '0;
            rsp_data_in.blocked       = found_ff;
            rsp_data_in.block_reason  = found_ff ? best_r_ff : '0;
            rsp_data_in.active_count  = 4'(w_ff);
            rsp_data_in.tracked_nodes = 5'(tracked_ff);
            rsp_data_in.dropped       = drop_ff;
            rsp_user_in = 1'b0;
            rsp_last_in = 1'b1;
            stream_in   = 1'b0;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               if (stream_ff && emit_ff != w_ff) begin
                  state_in = ST_S_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         tracked_ff <= '0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         tracked_ff <= tracked_in;
      end
   end

   // item, walk and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      kind_ff     <= kind_in;
      timed_ff    <= timed_in;
      dur_ff      <= dur_in;
      iss_ff      <= iss_in;
      reason_ff   <= reason_in;
      now_ff      <= now_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      cnt_ff      <= cnt_in;
      i_ff        <= i_in;
      w_ff        <= w_in;
      emit_ff     <= emit_in;
      found_ff    <= found_in;
      best_t_ff   <= best_t_in;
      best_r_ff   <= best_r_in;
      drop_ff     <= drop_in;
      stream_ff   <= stream_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // node count tracks the valid bits
   a_tracked_count: assert property (@(posedge clock) disable iff (reset)
      tracked_ff == NC_W'($countones(used_ff)))
      else $error("tracked node count differs from valid bits");

   // one item at a time
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");

   // live entries never outnumber the list during a walk
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_RD || state_ff == ST_C_RD) |-> (w_ff <= i_ff && i_ff <= cnt_ff))
      else $error("list walk out of range");

   // a streamed entry word never exceeds the live count
   a_stream_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (emit_ff <= w_ff && emit_ff != '0))
      else $error("streamed more entries than counted");

endmodule
